// ===== rtl/slpc_pkg.sv =====
// Shared types, constants and register codes for the switch latch power controller.
package slpc_pkg;

	// Field widths.
	localparam int DebWidth    = 8;
	localparam int AutoWidth   = 20;
	localparam int SettleWidth = 10;
	localparam int HoldWidth   = 10;
	localparam int CountWidth  = 10;
	localparam int PhaseWidth  = 3;
	localparam int CfgIdxWidth = 3;
	localparam int CfgDatWidth = 20;

	// Configuration register indexes.
	localparam logic [CfgIdxWidth-1:0] RegDebounce = 3'd0;
	localparam logic [CfgIdxWidth-1:0] RegAutoOff  = 3'd1;
	localparam logic [CfgIdxWidth-1:0] RegSettle   = 3'd2;
	localparam logic [CfgIdxWidth-1:0] RegHold     = 3'd3;

	// Register reset values.
	localparam logic [DebWidth-1:0]    DebReset    = 8'd20;
	localparam logic [AutoWidth-1:0]   AutoReset   = 20'd600000;
	localparam logic [SettleWidth-1:0] SettleReset = 10'd200;
	localparam logic [HoldWidth-1:0]   HoldReset   = 10'd1000;

	// Phase codes as they appear on the result stream.
	localparam logic [PhaseWidth-1:0] CodeStart   = 3'd0;
	localparam logic [PhaseWidth-1:0] CodeHold    = 3'd1;
	localparam logic [PhaseWidth-1:0] CodeRelease = 3'd2;
	localparam logic [PhaseWidth-1:0] CodeSettle  = 3'd3;
	localparam logic [PhaseWidth-1:0] CodeRun     = 3'd4;

	// Sequencer phase, one-hot.
	typedef enum logic [4:0] {
		PH_START   = 5'b00001,
		PH_HOLD    = 5'b00010,
		PH_RELEASE = 5'b00100,
		PH_SETTLE  = 5'b01000,
		PH_RUN     = 5'b10000
	} phase_t;

	// Current configuration as seen by the core.
	typedef struct packed {
		logic [DebWidth-1:0]    debounce_ticks;
		logic [AutoWidth-1:0]   auto_off_ticks;
		logic [SettleWidth-1:0] settle_ticks;
		logic [HoldWidth-1:0]   hold_ticks;
	} cfg_t;

	// One pin sample.
	typedef struct packed {
		logic switch_level;
		logic input_level;
		logic tick;
	} sample_t;

	// One result beat.
	typedef struct packed {
		logic [PhaseWidth-1:0] run_phase;
		logic                  power_hold;
		logic                  led_power;
		logic                  led_output;
		logic                  latched_output;
	} result_t;

endpackage

// ===== rtl/slpc_cfg.sv =====
// Configuration register bank of the switch latch power controller.
module slpc_cfg import slpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgDatWidth-1:0] cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped and extra data bits ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DebReset;
			cfg_q.auto_off_ticks <= AutoReset;
			cfg_q.settle_ticks   <= SettleReset;
			cfg_q.hold_ticks     <= HoldReset;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				RegDebounce: cfg_q.debounce_ticks <= cfg_data[DebWidth-1:0];
				RegAutoOff:  cfg_q.auto_off_ticks <= cfg_data[AutoWidth-1:0];
				RegSettle:   cfg_q.settle_ticks   <= cfg_data[SettleWidth-1:0];
				RegHold:     cfg_q.hold_ticks     <= cfg_data[HoldWidth-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/slpc_core.sv =====
// Sequencer, debounce, auto-off and blink state with its next-state logic.
module slpc_core import slpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  sample_t sample,
	input  cfg_t    cfg,
	output result_t result
);

	phase_t                 phase_q, n_phase;
	logic                   bat_q, n_bat;
	logic [CountWidth-1:0]  pc_q, n_pc, settle_base;
	logic [AutoWidth-1:0]   act_q, n_act;
	logic [DebWidth-1:0]    deb_q, n_deb;
	logic                   pressed_q, n_pressed;
	logic                   latched_q, n_latched;
	logic                   blink_q, n_blink;
	logic                   plat_q, n_plat;
	logic                   oled_q, n_oled;
	logic                   pled_q, n_pled;
	logic                   settle_go;
	logic [PhaseWidth-1:0]  phase_code;

	// Next state for one sample.
	always_comb begin
		n_phase     = phase_q;
		n_bat       = bat_q;
		n_pc        = pc_q;
		n_act       = act_q;
		n_deb       = deb_q;
		n_pressed   = pressed_q;
		n_latched   = latched_q;
		n_blink     = blink_q;
		n_plat      = plat_q;
		n_oled      = oled_q;
		n_pled      = pled_q;
		settle_go   = 1'b0;
		settle_base = pc_q;
		unique case (phase_q)
			PH_START: begin
				n_act = cfg.auto_off_ticks;
				n_pc  = '0;
				if (!sample.switch_level) begin
					n_bat   = 1'b1;
					n_phase = PH_HOLD;
				end else begin
					n_phase = PH_RUN;
				end
			end
			PH_HOLD: begin
				if (sample.tick && (pc_q < cfg.hold_ticks)) begin
					n_pc = pc_q + 10'd1;
				end
				if (n_pc >= cfg.hold_ticks) begin
					n_plat  = 1'b1;
					n_phase = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (!sample.switch_level) begin
					if (sample.tick) begin
						n_pled  = blink_q;
						n_blink = ~blink_q;
					end
				end else begin
					settle_go   = 1'b1;
					settle_base = '0;
				end
			end
			PH_SETTLE: begin
				settle_go = 1'b1;
			end
			default: begin
				// Running: blink, auto-off countdown and debounced toggle.
				if (sample.tick) begin
					n_blink = ~blink_q;
					if (bat_q && (act_q != '0)) begin
						n_act = act_q - 20'd1;
						if (act_q == 20'd1) begin
							n_plat = 1'b0;
						end
					end
					n_oled = latched_q ? ~blink_q : 1'b0;
					n_pled = ~blink_q;
					if (deb_q != '0) begin
						n_deb = deb_q - 8'd1;
					end
				end
				if (n_deb == '0) begin
					if (pressed_q) begin
						if (sample.input_level) begin
							n_pressed = 1'b0;
							n_deb     = cfg.debounce_ticks;
							n_act     = cfg.auto_off_ticks;
						end
					end else if (!sample.input_level) begin
						n_pressed = 1'b1;
						n_deb     = cfg.debounce_ticks;
						n_act     = cfg.auto_off_ticks;
						n_latched = ~latched_q;
					end
				end
				if (!sample.switch_level) begin
					n_plat = 1'b0;
				end
			end
		endcase

		// Settle counting, also run on the sample that sees the switch released.
		if (settle_go) begin
			n_pc = settle_base;
			if (sample.tick && (settle_base < cfg.settle_ticks)) begin
				n_pled  = blink_q;
				n_blink = ~blink_q;
				n_pc    = settle_base + 10'd1;
			end
			n_phase = (n_pc >= cfg.settle_ticks) ? PH_RUN : PH_SETTLE;
		end
	end

	// State registers, updated on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			bat_q     <= 1'b0;
			pc_q      <= '0;
			act_q     <= AutoReset;
			deb_q     <= '0;
			pressed_q <= 1'b1;
			latched_q <= 1'b0;
			blink_q   <= 1'b0;
			plat_q    <= 1'b0;
			oled_q    <= 1'b0;
			pled_q    <= 1'b0;
		end else if (accept) begin
			phase_q   <= n_phase;
			bat_q     <= n_bat;
			pc_q      <= n_pc;
			act_q     <= n_act;
			deb_q     <= n_deb;
			pressed_q <= n_pressed;
			latched_q <= n_latched;
			blink_q   <= n_blink;
			plat_q    <= n_plat;
			oled_q    <= n_oled;
			pled_q    <= n_pled;
		end
	end

	// Phase encoding for the result stream.
	always_comb begin
		unique case (n_phase)
			PH_START:   phase_code = CodeStart;
			PH_HOLD:    phase_code = CodeHold;
			PH_RELEASE: phase_code = CodeRelease;
			PH_SETTLE:  phase_code = CodeSettle;
			default:    phase_code = CodeRun;
		endcase
	end

	assign result.latched_output = n_latched;
	assign result.led_output     = n_oled;
	assign result.led_power      = n_pled;
	assign result.power_hold     = n_plat;
	assign result.run_phase      = phase_code;

	// The power latch is only ever set on battery supply.
	a_latch_needs_battery: assert property (@(posedge clk) disable iff (!arst_n)
		plat_q |-> bat_q)
		else $error("power latch set without battery mode");

	// The supply mode is fixed once the start sample has passed.
	a_mode_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_START) |=> $stable(bat_q))
		else $error("supply mode changed after start");

	// Running is never left.
	a_run_absorbing: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RUN) |=> (phase_q == PH_RUN))
		else $error("left running phase");

endmodule

// ===== rtl/switch_latch_power_controller.sv =====
// Top level of the switch latch power controller: ports, core and result register.
//
//  channel   direction  fields (low bit first)
//  s_*       in         tick, input_level, switch_level
//  m_*       out        latched_output, led_output, led_power, power_hold, run_phase[2:0]
//  cfg_*     in         write enable, register index, write data
//
// Each sample beat yields one result beat in the cycle after it is accepted, from the result register.
// A new sample is taken every cycle while the result register is empty or being drained.
// When m_tready is low with a result waiting, s_tready drops until the result is taken.
// Reset loads the register defaults and puts the sequencer in its start phase.
module switch_latch_power_controller import slpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // tick, input_level, switch_level
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,   // latched_output, led_output, led_power,
	                                          // power_hold, run_phase[2:0]
	input  logic                   cfg_wen,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgDatWidth-1:0] cfg_data
);

	cfg_t    cfg;
	sample_t sample;
	result_t result, result_s1;
	logic    accept;
	logic    m_tvalid_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign sample.tick         = s_tdata[0];
	assign sample.input_level  = s_tdata[1];
	assign sample.switch_level = s_tdata[2];

	slpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	slpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.cfg    (cfg),
		.result (result)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= accept;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, result_s1};

	// With no result waiting, the input is always ready.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid_q |-> s_tready)
		else $error("input stalled with empty result register");

	// Every accepted sample leaves a result in the register.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid_q)
		else $error("accepted sample produced no result");

	// A result disappears only when taken.
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> m_tvalid_q)
		else $error("waiting result lost");

endmodule

// ===== tb/switch_latch_power_controller_test.sv =====
// Self-checking stream testbench for the switch latch power controller.
`timescale 1ns / 1ps

module switch_latch_power_controller_test;
	import slpc_pkg::*;

	// Run limits.
	localparam int CycleLimit = 300000;
	localparam int PhaseCount = 6;
	localparam int PhaseItems = 100;
	localparam int SettleMax  = (1 << SettleWidth) - 1;
	localparam int HoldMax    = (1 << HoldWidth) - 1;
	localparam int RegTop     = (1 << CfgIdxWidth) - 1;
	localparam logic [CfgDatWidth-1:0] AutoMax = '1;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = '0;   // tick, input_level, switch_level
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [7:0]             m_tdata;        // latched_output, led_output, led_power,
	                                        // power_hold, run_phase[2:0]
	logic                   cfg_wen = 1'b0;
	logic [CfgIdxWidth-1:0] cfg_index = '0;
	logic [CfgDatWidth-1:0] cfg_data = '0;

	switch_latch_power_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Samples waiting to be sent and pin states expected back.
	sample_t pending_samples[$];
	result_t expected_results[$];
	int      mismatches = 0;
	int      cycles = 0;
	bit      quiet = 1'b0;
	bit      s_taken = 1'b0;
	int      send_gap = 0;
	int      recv_gap = 0;

	// Shadow of the controller: registers and sequencer state.
	cfg_t             regs = '{DebReset, AutoReset, SettleReset, HoldReset};
	phase_t           seq_phase = PH_START;
	logic             on_batt = 1'b0;
	logic [CountWidth-1:0] phase_cnt = '0;
	logic [AutoWidth-1:0]  idle_cnt = AutoReset;
	logic [DebWidth-1:0]   bounce_cnt = '0;
	logic             in_held = 1'b1;
	logic             out_state = 1'b0;
	logic             blink = 1'b0;
	logic             hold_latch = 1'b0;
	logic             out_led_q = 1'b0;
	logic             pwr_led_q = 1'b0;

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Settle work: blink the power LED per tick until the settle count is reached.
	function automatic void settle_step(input logic tk);
		if (tk && phase_cnt < regs.settle_ticks) begin
			pwr_led_q = blink;
			blink = ~blink;
			phase_cnt = phase_cnt + 1'b1;
		end
		if (phase_cnt >= regs.settle_ticks)
			seq_phase = PH_RUN;
	endfunction

	// Advance the shadow by one sample and return the pins it leaves behind.
	function automatic result_t step_sample(input sample_t smp);
		result_t r;
		case (seq_phase)
			PH_START: begin
				idle_cnt = regs.auto_off_ticks;
				phase_cnt = '0;
				if (!smp.switch_level) begin
					on_batt = 1'b1;
					seq_phase = PH_HOLD;
				end else begin
					seq_phase = PH_RUN;
				end
			end
			PH_HOLD: begin
				if (smp.tick && phase_cnt < regs.hold_ticks)
					phase_cnt = phase_cnt + 1'b1;
				if (phase_cnt >= regs.hold_ticks) begin
					hold_latch = 1'b1;
					seq_phase = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (!smp.switch_level) begin
					if (smp.tick) begin
						pwr_led_q = blink;
						blink = ~blink;
					end
				end else begin
					seq_phase = PH_SETTLE;
					phase_cnt = '0;
					settle_step(smp.tick);
				end
			end
			PH_SETTLE: settle_step(smp.tick);
			default: begin
				// Tick bookkeeping: blink, auto-off countdown, debounce countdown.
				if (smp.tick) begin
					blink = ~blink;
					if (on_batt && idle_cnt != 0) begin
						idle_cnt = idle_cnt - 1'b1;
						if (idle_cnt == 0)
							hold_latch = 1'b0;
					end
					out_led_q = out_state ? blink : 1'b0;
					pwr_led_q = blink;
					if (bounce_cnt != 0)
						bounce_cnt = bounce_cnt - 1'b1;
				end
				// Accept an input edge once the debounce window is over.
				if (bounce_cnt == 0) begin
					if (in_held) begin
						if (smp.input_level) begin
							in_held = 1'b0;
							bounce_cnt = regs.debounce_ticks;
							idle_cnt = regs.auto_off_ticks;
						end
					end else if (!smp.input_level) begin
						in_held = 1'b1;
						bounce_cnt = regs.debounce_ticks;
						idle_cnt = regs.auto_off_ticks;
						out_state = ~out_state;
					end
				end
				if (!smp.switch_level)
					hold_latch = 1'b0;
			end
		endcase
		r.latched_output = out_state;
		r.led_output     = out_led_q;
		r.led_power      = pwr_led_q;
		r.power_hold     = hold_latch;
		case (seq_phase)
			PH_START:   r.run_phase = CodeStart;
			PH_HOLD:    r.run_phase = CodeHold;
			PH_RELEASE: r.run_phase = CodeRelease;
			PH_SETTLE:  r.run_phase = CodeSettle;
			default:    r.run_phase = CodeRun;
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [PhaseWidth-1:0] want,
		input logic [PhaseWidth-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Sample sender: one sample per beat, random gaps between beats.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !s_taken) begin
			// Beat still waiting for ready.
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			s_tvalid <= 1'b0;
		end else if (pending_samples.size() > 0) begin
			s_tdata <= {{(8 - $bits(sample_t)){1'b0}}, pending_samples.pop_front()};
			s_tvalid <= 1'b1;
			send_gap <= quiet ? 0 : gap_len();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Result receiver: random stalls on ready.
	always @(negedge clk) begin
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 99) < 25)
				recv_gap <= gap_len();
		end
	end

	// Monitor: check each result beat, then predict from each accepted sample beat.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		s_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(result_t)-1:0];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, actual %h", $time, got);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("latched_output", PhaseWidth'(want.latched_output),
						PhaseWidth'(got.latched_output));
					check_field("led_output", PhaseWidth'(want.led_output),
						PhaseWidth'(got.led_output));
					check_field("led_power", PhaseWidth'(want.led_power),
						PhaseWidth'(got.led_power));
					check_field("power_hold", PhaseWidth'(want.power_hold),
						PhaseWidth'(got.power_hold));
					check_field("run_phase", want.run_phase, got.run_phase);
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(step_sample(s_tdata[$bits(sample_t)-1:0]));
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Register write, mirrored into the shadow with the same masking.
	task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
		input logic [CfgDatWidth-1:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			RegDebounce: regs.debounce_ticks = val[DebWidth-1:0];
			RegAutoOff:  regs.auto_off_ticks = val[AutoWidth-1:0];
			RegSettle:   regs.settle_ticks   = val[SettleWidth-1:0];
			RegHold:     regs.hold_ticks     = val[HoldWidth-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic add_sample(input logic tk, input logic lvl_in, input logic lvl_sw);
		sample_t smp;
		smp.tick = tk;
		smp.input_level = lvl_in;
		smp.switch_level = lvl_sw;
		pending_samples.push_back(smp);
	endtask

	// Block until every sample is sent and every result is back.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	initial begin
		int p;
		int n;
		int tick_pct;
		int sw_pct;
		int run_left;
		logic in_lvl;
		logic [CfgDatWidth-1:0] deb_val;
		logic [CfgDatWidth-1:0] auto_val;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Long hold and settle so both counts can be watched, then cut short.
		write_reg(RegHold, CfgDatWidth'(HoldMax));
		write_reg(RegSettle, CfgDatWidth'(SettleMax));
		write_reg(RegDebounce, 2);
		write_reg(RegAutoOff, AutoMax);
		write_reg(CfgIdxWidth'($urandom_range(RegHold + 1, RegTop)), CfgDatWidth'($urandom));

		// Start with the switch pressed: battery mode; the start tick is not counted.
		add_sample(1'b1, 1'b1, 1'b0);
		add_sample(1'b1, 1'b0, 1'b0);
		add_sample(1'b0, 1'b1, 1'b0);
		add_sample(1'b1, 1'b1, 1'b0);
		wait_drained();
		// Hold count already past a zero hold time: latch on the next sample.
		write_reg(RegHold, 0);
		add_sample(1'b0, 1'b0, 1'b0);
		// Waiting for release: power LED blinks per tick.
		add_sample(1'b1, 1'b1, 1'b0);
		add_sample(1'b0, 1'b0, 1'b0);
		add_sample(1'b1, 1'b1, 1'b0);
		// Release with a tick: settle work runs in the same sample.
		add_sample(1'b1, 1'b1, 1'b1);
		add_sample(1'b1, 1'b0, 1'b1);
		add_sample(1'b0, 1'b1, 1'b1);
		add_sample(1'b1, 1'b1, 1'b1);
		wait_drained();
		write_reg(RegSettle, 0);
		write_reg(RegDebounce, 0);
		// Settle ends at once, then presses toggle with no debounce.
		add_sample(1'b0, 1'b1, 1'b1);
		add_sample(1'b1, 1'b0, 1'b1);
		add_sample(1'b0, 1'b1, 1'b1);
		add_sample(1'b1, 1'b1, 1'b1);
		add_sample(1'b1, 1'b0, 1'b1);
		add_sample(1'b0, 1'b0, 1'b1);
		add_sample(1'b1, 1'b1, 1'b1);
		wait_drained();
		// Debounce window swallows the release until two ticks pass.
		write_reg(RegDebounce, 2);
		add_sample(1'b0, 1'b0, 1'b1);
		add_sample(1'b1, 1'b1, 1'b1);
		add_sample(1'b1, 1'b1, 1'b1);
		add_sample(1'b0, 1'b1, 1'b1);

		// Random running traffic: input held in runs of random length, rare switch presses.
		in_lvl = 1'b1;
		run_left = 0;
		for (p = 0; p < PhaseCount; p++) begin
			wait_drained();
			quiet = (p == 2) || ($urandom_range(0, 3) == 0);
			case (p)
				0: begin
					deb_val = 0;
					auto_val = 0;
					tick_pct = 50;
					sw_pct = 0;
				end
				1: begin
					deb_val = CfgDatWidth'($urandom_range(1, 5));
					auto_val = CfgDatWidth'($urandom_range(20, 80));
					tick_pct = 70;
					sw_pct = 0;
				end
				2: begin
					deb_val = 1;
					auto_val = 1;
					tick_pct = 30;
					sw_pct = 2;
				end
				3: begin
					// Full debounce, with junk above the register width.
					deb_val = CfgDatWidth'({$urandom, 8'hFF});
					auto_val = AutoMax;
					tick_pct = 100;
					sw_pct = 1;
				end
				default: begin
					deb_val = CfgDatWidth'($urandom_range(0, 10));
					auto_val = CfgDatWidth'($urandom_range(0, 200));
					tick_pct = $urandom_range(10, 100);
					sw_pct = 2;
				end
			endcase
			write_reg(RegDebounce, deb_val);
			write_reg(RegAutoOff, auto_val);
			write_reg(RegSettle, CfgDatWidth'($urandom_range(0, SettleMax)));
			write_reg(RegHold, CfgDatWidth'($urandom_range(0, HoldMax)));
			write_reg(CfgIdxWidth'($urandom_range(RegHold + 1, RegTop)),
				CfgDatWidth'($urandom));
			for (n = 0; n < PhaseItems; n++) begin
				if (run_left == 0) begin
					in_lvl = ~in_lvl;
					run_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 15);
				end
				run_left--;
				add_sample($urandom_range(0, 99) < tick_pct, in_lvl,
					!($urandom_range(0, 99) < sw_pct));
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/slpc_pkg.sv
rtl/slpc_cfg.sv
rtl/slpc_core.sv
rtl/switch_latch_power_controller.sv
tb/switch_latch_power_controller_test.sv
